// ===== rtl/core/coc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, opcodes and widths of the orthonormality check unit
// no dependencies

package coc_pkg;

  localparam int MAX_DIM_DEF = 64;
  localparam int IDX_W       = 8;    // holds any index up to the largest MAX_DIM

  localparam int OP_W    = 2;
  localparam int ROW_W   = 6;
  localparam int VAL_W   = 48;
  localparam int RES_W   = 64;
  localparam int CNT_CFG_W = 7;
  localparam int TOL_W   = 47;
  localparam int ACC_W   = 128;
  localparam int PROD_W  = 112;

  localparam logic [OP_W-1:0] OP_LOAD_S = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_C = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  localparam logic [1:0] REG_BASIS   = 2'd0;
  localparam logic [1:0] REG_ORBITAL = 2'd1;
  localparam logic [1:0] REG_TOL     = 2'd2;
  localparam logic [1:0] REG_OVERLAP = 2'd3;

  localparam logic [CNT_CFG_W-1:0] BASIS_RST = 7'd1;
  localparam logic [CNT_CFG_W-1:0] ORB_RST   = 7'd1;
  localparam logic [TOL_W-1:0]     TOL_RST   = 47'd10995;

  localparam logic [RES_W-1:0] ONE_Q40 = 64'h0000_0100_0000_0000;

  typedef struct packed {
    logic [CNT_CFG_W-1:0] basis_count;
    logic [CNT_CFG_W-1:0] orbital_count;
    logic [TOL_W-1:0]     tolerance;
    logic                 overlap_present;
  } cfg_t;

  typedef struct packed {
    logic             wr_s;      // store the accepted overlap element
    logic             wr_c;      // store the accepted coefficient element
    logic             rd;        // read both operands of one term
    logic             phase_t;   // second product pass, uses row products
    logic             latch;     // take operand magnitudes and signs
    logic             pp;        // add one partial product
    logic [1:0]       pp_idx;
    logic             acc_clr;
    logic             acc_add;
    logic             rnd;       // round and saturate the sum
    logic             wr_rp;     // keep the rounded sum as a row product
    logic             eval;      // tolerance test of the rounded sum
    logic             diag;
    logic             res_load;
    logic             res_pass;
    logic [IDX_W-1:0] i_idx;
    logic [IDX_W-1:0] jj_idx;
    logic [IDX_W-1:0] k_idx;
    logic [IDX_W-1:0] l_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
  } dp_stat_t;

endpackage

// ===== rtl/core/coc_in_if.sv =====
`timescale 1ns / 1ps
// input channel of the orthonormality check unit
// depends on coc_pkg

interface coc_in_if;
  import coc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [ROW_W-1:0]        row;
  logic [ROW_W-1:0]        col;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, op, row, col, value, input ready);
  modport sink (input valid, op, row, col, value, output ready);
endinterface

// ===== rtl/core/coc_out_if.sv =====
`timescale 1ns / 1ps
// result channel of the orthonormality check unit
// depends on coc_pkg

interface coc_out_if;
  import coc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    passed;
  logic [ROW_W-1:0]        fail_row;
  logic [ROW_W-1:0]        fail_col;
  logic signed [RES_W-1:0] fail_value;

  modport source (output valid, passed, fail_row, fail_col, fail_value, input ready);
  modport sink (input valid, passed, fail_row, fail_col, fail_value, output ready);
endinterface

// ===== rtl/core/congruence_orthonormality_check_unit.sv =====
`timescale 1ns / 1ps
// top level of the orthonormality check unit: register port, controller, datapath
// depends on coc_pkg, coc_in_if, coc_out_if, coc_ctrl, coc_dp

// Load transactions (overlap or coefficient element) are accepted back to
// back while the controller is idle, also while a check result still waits
// on the output. A check transaction holds the input off while it runs; its
// run time is set by the single shared multiplier (four 24x32 partial
// products plus a read, a latch and an accumulate per term) and by the
// rounding and testing of each element. With no overlap present the check
// goes straight to the finish state, which loads the pass result into the
// output register once the output is free. Registers sit on the APB port at
// 8-byte steps: basis_count, orbital_count, tolerance, overlap_present. The
// element stores hold no reset value; check only elements that have been loaded.
module congruence_orthonormality_check_unit #(
  parameter int MAX_DIM = coc_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  coc_in_if.sink      in_ch,
  coc_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import coc_pkg::*;

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     wr_en;
  logic [1:0] reg_idx;

  // register file, written on the access phase
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.basis_count     <= BASIS_RST;
      cfg_r.orbital_count   <= ORB_RST;
      cfg_r.tolerance       <= TOL_RST;
      cfg_r.overlap_present <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BASIS:   cfg_r.basis_count     <= cfg_pwdata[CNT_CFG_W-1:0];
        REG_ORBITAL: cfg_r.orbital_count   <= cfg_pwdata[CNT_CFG_W-1:0];
        REG_TOL:     cfg_r.tolerance       <= cfg_pwdata[TOL_W-1:0];
        REG_OVERLAP: cfg_r.overlap_present <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_BASIS:   cfg_prdata = 64'(cfg_r.basis_count);
      REG_ORBITAL: cfg_prdata = 64'(cfg_r.orbital_count);
      REG_TOL:     cfg_prdata = 64'(cfg_r.tolerance);
      REG_OVERLAP: cfg_prdata = 64'(cfg_r.overlap_present);
      default:     cfg_prdata = '0;
    endcase
  end

  coc_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  coc_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .ld_row     (in_ch.row),
    .ld_col     (in_ch.col),
    .ld_value   (in_ch.value),
    .tolerance  (cfg_r.tolerance),
    .stat       (stat),
    .res_passed (out_ch.passed),
    .res_row    (out_ch.fail_row),
    .res_col    (out_ch.fail_col),
    .res_value  (out_ch.fail_value)
  );

endmodule

// ===== rtl/core/coc_dp.sv =====
`timescale 1ns / 1ps
// datapath: element stores, serial multiplier, accumulator, rounding, test, result register
// depends on coc_pkg

module coc_dp #(
  parameter int MAX_DIM = coc_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  coc_pkg::dp_cmd_t                   cmd,
  input  logic [coc_pkg::ROW_W-1:0]          ld_row,
  input  logic [coc_pkg::ROW_W-1:0]          ld_col,
  input  logic [coc_pkg::VAL_W-1:0]          ld_value,
  input  logic [coc_pkg::TOL_W-1:0]          tolerance,
  output coc_pkg::dp_stat_t                  stat,
  output logic                               res_passed,
  output logic [coc_pkg::ROW_W-1:0]          res_row,
  output logic [coc_pkg::ROW_W-1:0]          res_col,
  output logic [coc_pkg::RES_W-1:0]          res_value
);
  import coc_pkg::*;

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int TRI   = MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int TW    = (TRI > 1) ? $clog2(TRI) : 1;
  localparam int CDEP  = MAX_DIM * MAX_DIM;
  localparam int CAW   = (CDEP > 1) ? $clog2(CDEP) : 1;

  logic [VAL_W-1:0] s_mem [TRI];
  logic [VAL_W-1:0] c_mem [CDEP];
  logic [RES_W-1:0] rp_mem [MAX_DIM];

  logic [VAL_W-1:0] s_q_r, c_q_r;
  logic [RES_W-1:0] rp_q_r;

  logic [IW-1:0]  ci, cj, l_i, k_i, tr_hi, tr_lo, ld_r_i, ld_c_i;
  logic [TW-1:0]  s_rd_addr, s_wr_addr;
  logic [CAW-1:0] c_rd_addr, c_wr_addr;
  logic [2*IW:0]  tri_rd, tri_wr;

  // operand indices of the current term
  always_comb begin
    l_i   = IW'(cmd.l_idx);
    k_i   = IW'(cmd.k_idx);
    ci    = cmd.phase_t ? IW'(cmd.jj_idx) : IW'(cmd.i_idx);
    cj    = cmd.phase_t ? k_i : l_i;
    tr_hi = (l_i > k_i) ? l_i : k_i;
    tr_lo = (l_i > k_i) ? k_i : l_i;
    tri_rd = ((2*IW+1)'(tr_hi) * (2*IW+1)'({1'b0, tr_hi} + 1'b1)) >> 1;
    s_rd_addr = TW'(tri_rd + (2*IW+1)'(tr_lo));
    c_rd_addr = CAW'(ci * MAX_DIM + cj);
    ld_r_i = IW'(ld_row);
    ld_c_i = IW'(ld_col);
    tri_wr = ((2*IW+1)'(ld_r_i) * (2*IW+1)'({1'b0, ld_r_i} + 1'b1)) >> 1;
    s_wr_addr = TW'(tri_wr + (2*IW+1)'(ld_c_i));
    c_wr_addr = CAW'(ld_r_i * MAX_DIM + ld_c_i);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_s) begin
      s_mem[s_wr_addr] <= ld_value;
    end
    if (cmd.rd) begin
      s_q_r <= s_mem[s_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_c) begin
      c_mem[c_wr_addr] <= ld_value;
    end
    if (cmd.rd) begin
      c_q_r <= c_mem[c_rd_addr];
    end
  end

  logic [RES_W-1:0] t_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_rp) begin
      rp_mem[k_i] <= t_r;
    end
    if (cmd.rd) begin
      rp_q_r <= rp_mem[k_i];
    end
  end

  // serial multiplier: 24 x 32 partial products, added one at a time
  logic [VAL_W-1:0]  ma_r;
  logic [RES_W-1:0]  mb_r;
  logic              neg_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic [RES_W-1:0]  b_op;
  logic [23:0]       a_part;
  logic [31:0]       b_part;
  logic [55:0]       pp;
  logic [PROD_W-1:0] pp_sh;

  always_comb begin
    b_op   = cmd.phase_t ? rp_q_r : {{(RES_W-VAL_W){s_q_r[VAL_W-1]}}, s_q_r};
    a_part = cmd.pp_idx[0] ? ma_r[47:24] : ma_r[23:0];
    b_part = cmd.pp_idx[1] ? mb_r[63:32] : mb_r[31:0];
    pp     = 56'(a_part) * 56'(b_part);
    case (cmd.pp_idx)
      2'd0:    pp_sh = PROD_W'(pp);
      2'd1:    pp_sh = PROD_W'(pp) << 24;
      2'd2:    pp_sh = PROD_W'(pp) << 32;
      default: pp_sh = PROD_W'(pp) << 56;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ma_r   <= c_q_r[VAL_W-1] ? (~c_q_r + 1'b1) : c_q_r;
      mb_r   <= b_op[RES_W-1] ? (~b_op + 1'b1) : b_op;
      neg_r  <= c_q_r[VAL_W-1] ^ b_op[RES_W-1];
      prod_r <= '0;
    end else if (cmd.pp) begin
      prod_r <= prod_r + pp_sh;
    end
  end

  // accumulate with conditional negation folded into the carry in
  logic [ACC_W-1:0] prod_x;
  assign prod_x = ACC_W'(prod_r) ^ {ACC_W{neg_r}};

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + prod_x + ACC_W'(neg_r);
    end
  end

  // round half up at bit 40, saturate to 64 bits
  logic [ACC_W-1:0] rsum;
  logic [RES_W-1:0] t_nxt;
  always_comb begin
    rsum = acc_r + (ACC_W'(1) << 39);
    if ((&rsum[127:103]) || !(|rsum[127:103])) begin
      t_nxt = rsum[103:40];
    end else begin
      t_nxt = rsum[127] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rnd) begin
      t_r <= t_nxt;
    end
  end

  // tolerance test
  logic [RES_W-1:0] mag, dev, dev_sel;
  logic             bad_r;
  always_comb begin
    mag = t_r[RES_W-1] ? (~t_r + 1'b1) : t_r;
    dev = (mag >= ONE_Q40) ? (mag - ONE_Q40) : (ONE_Q40 - mag);
    dev_sel = cmd.diag ? dev : mag;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      bad_r <= dev_sel > RES_W'(tolerance);
    end
  end
  assign stat.bad = bad_r;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_passed <= cmd.res_pass;
      res_row    <= cmd.res_pass ? '0 : ROW_W'(cmd.i_idx);
      res_col    <= cmd.res_pass ? '0 : ROW_W'(cmd.jj_idx);
      res_value  <= cmd.res_pass ? '0 : t_r;
    end
  end

endmodule

// ===== rtl/core/coc_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences loads, the two product passes and the tolerance scan
// depends on coc_pkg

module coc_ctrl #(
  parameter int MAX_DIM = coc_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  coc_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [coc_pkg::OP_W-1:0]    in_op,
  input  logic [coc_pkg::ROW_W-1:0]   in_row,
  input  logic [coc_pkg::ROW_W-1:0]   in_col,
  output logic                        out_valid,
  input  logic                        out_ready,
  output coc_pkg::dp_cmd_t            cmd,
  input  coc_pkg::dp_stat_t           stat
);
  import coc_pkg::*;

  localparam int CW = $clog2(MAX_DIM + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ROW    = 4'd1;
  localparam logic [3:0] S_W_K    = 4'd2;
  localparam logic [3:0] S_W_L    = 4'd3;
  localparam logic [3:0] S_T_J    = 4'd4;
  localparam logic [3:0] S_T_K    = 4'd5;
  localparam logic [3:0] S_LATCH  = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_ACC    = 4'd8;
  localparam logic [3:0] S_RND_W  = 4'd9;
  localparam logic [3:0] S_WR_RP  = 4'd10;
  localparam logic [3:0] S_RND_T  = 4'd11;
  localparam logic [3:0] S_EVAL   = 4'd12;
  localparam logic [3:0] S_CHECK  = 4'd13;
  localparam logic [3:0] S_FINISH = 4'd14;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, l_r, l_nxt;
  logic [1:0]    pp_r, pp_nxt;
  logic          phase_r, phase_nxt;
  logic          pass_r, pass_nxt;
  logic          ov_r, ov_nxt;
  logic [CW-1:0] nb, no, jj;
  logic          acc_in;

  always_comb begin
    nb = (cfg.basis_count > MAX_DIM) ? CW'(MAX_DIM) : CW'(cfg.basis_count);
    no = (cfg.orbital_count > MAX_DIM) ? CW'(MAX_DIM) : CW'(cfg.orbital_count);
    jj = (j_r == '0) ? i_r : (j_r - 1'b1);
  end

  assign in_ready = (state_r == S_IDLE);
  assign acc_in   = in_valid && in_ready;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; l_nxt = l_r;
    pp_nxt = pp_r; phase_nxt = phase_r; pass_nxt = pass_r;
    ov_nxt = ov_r && !out_ready;
    cmd = '0;
    cmd.phase_t = phase_r;
    cmd.pp_idx  = pp_r;
    cmd.i_idx   = IDX_W'(i_r);
    cmd.jj_idx  = IDX_W'(jj);
    cmd.k_idx   = IDX_W'(k_r);
    cmd.l_idx   = IDX_W'(l_r);
    cmd.diag    = (j_r == '0);
    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          if (in_op == OP_LOAD_S) begin
            cmd.wr_s = (in_row < MAX_DIM) && (in_col < MAX_DIM) && (in_col <= in_row);
          end else if (in_op == OP_LOAD_C) begin
            cmd.wr_c = (in_row < MAX_DIM) && (in_col < MAX_DIM);
          end else if (in_op == OP_CHECK) begin
            i_nxt = '0;
            if (cfg.overlap_present) begin
              state_nxt = S_ROW;
            end else begin
              pass_nxt  = 1'b1;
              state_nxt = S_FINISH;
            end
          end
        end
      end
      S_ROW: begin
        if (i_r == no) begin
          pass_nxt  = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          k_nxt = '0;
          phase_nxt = 1'b0;
          state_nxt = S_W_K;
        end
      end
      S_W_K: begin
        if (k_r == nb) begin
          j_nxt = '0;
          phase_nxt = 1'b1;
          state_nxt = S_T_J;
        end else begin
          cmd.acc_clr = 1'b1;
          l_nxt = '0;
          state_nxt = S_W_L;
        end
      end
      S_W_L: begin
        if (l_r == nb) begin
          state_nxt = S_RND_W;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_LATCH;
        end
      end
      S_T_J: begin
        if (j_r > i_r) begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_ROW;
        end else begin
          cmd.acc_clr = 1'b1;
          k_nxt = '0;
          state_nxt = S_T_K;
        end
      end
      S_T_K: begin
        if (k_r == nb) begin
          state_nxt = S_RND_T;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_LATCH;
        end
      end
      S_LATCH: begin
        cmd.latch = 1'b1;
        pp_nxt = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.pp = 1'b1;
        pp_nxt = pp_r + 1'b1;
        if (pp_r == 2'd3) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        if (phase_r) begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_T_K;
        end else begin
          l_nxt = l_r + 1'b1;
          state_nxt = S_W_L;
        end
      end
      S_RND_W: begin
        cmd.rnd = 1'b1;
        state_nxt = S_WR_RP;
      end
      S_WR_RP: begin
        cmd.wr_rp = 1'b1;
        k_nxt = k_r + 1'b1;
        state_nxt = S_W_K;
      end
      S_RND_T: begin
        cmd.rnd = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.bad) begin
          pass_nxt  = 1'b0;
          state_nxt = S_FINISH;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_T_J;
        end
      end
      S_FINISH: begin
        if (!ov_r || out_ready) begin
          cmd.res_load = 1'b1;
          cmd.res_pass = pass_r;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      pass_r  <= 1'b0;
      phase_r <= 1'b0;
      pp_r    <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      l_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      pass_r  <= pass_nxt;
      phase_r <= phase_nxt;
      pp_r    <= pp_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      l_r     <= l_nxt;
    end
  end

endmodule

// ===== sim/congruence_orthonormality_check_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking bench of the orthonormality check unit: directed plan, then random phases
// depends on coc_pkg, coc_in_if, coc_out_if and congruence_orthonormality_check_unit

module congruence_orthonormality_check_unit_test;
  import coc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;   // reserved opcode, dropped by the block
  localparam int DIM = 64;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct packed {
    logic                    passed;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [RES_W-1:0] value;
  } verdict_t;

  // one row of the directed plan: a register write or one input transaction
  typedef struct {
    bit                is_cfg;
    logic [1:0]        reg_idx;
    logic [63:0]       data;
    logic [OP_W-1:0]   op;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    logic [VAL_W-1:0]  value;
    bit                typed;
    verdict_t          want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  coc_in_if  in_ch ();
  coc_out_if out_ch ();

  congruence_orthonormality_check_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the block: registers and element stores
  logic [CNT_CFG_W-1:0]    basis_sh;
  logic [CNT_CFG_W-1:0]    orbital_sh;
  logic [TOL_W-1:0]        tol_sh;
  logic                    overlap_sh;
  logic signed [VAL_W-1:0] overlap_mem [DIM*(DIM+1)/2];
  logic signed [VAL_W-1:0] coeff_mem [DIM*DIM];
  bit                      overlap_loaded [DIM*(DIM+1)/2];
  bit                      coeff_loaded [DIM*DIM];

  verdict_t verdict_q [$];   // check verdicts still owed by the block

  int errors = 0;
  int loads_sent = 0;
  int checks_sent = 0;
  int passes_seen = 0;
  int failures_seen = 0;
  int burst_left = 0;
  int hold_left = 0;         // long receiver hold-off, counted down by the receiver
  int stall_pct = 0;
  int stall_timer = 0;

  function automatic int tri_index(int r, int c);
    return r * (r + 1) / 2 + c;
  endfunction

  function automatic logic signed [VAL_W-1:0] overlap_at(int r, int c);
    if (c > r) return overlap_mem[tri_index(c, r)];
    return overlap_mem[tri_index(r, c)];
  endfunction

  // round half up at bit 40 and saturate to 64 signed bits
  function automatic logic signed [RES_W-1:0] round_q40(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    r = (a + (128'sd1 <<< 39)) >>> 40;
    if (&r[ACC_W-1:63] || ~|r[ACC_W-1:63]) return r[63:0];
    return r[ACC_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  function automatic int clamp_dim(logic [CNT_CFG_W-1:0] n);
    return (n > DIM) ? DIM : int'(n);
  endfunction

  // verdict of T = C S C^T, each orbital row scanned diagonal first
  function automatic verdict_t orthonormality_verdict();
    int nb, no;
    logic signed [ACC_W-1:0] acc;
    logic signed [RES_W-1:0] w [DIM];
    logic signed [RES_W-1:0] t;
    logic [RES_W-1:0] mag, dev;
    int jj;
    bit bad;
    verdict_t v;
    v = '0;
    v.passed = 1'b1;
    if (!overlap_sh) return v;
    nb = clamp_dim(basis_sh);
    no = clamp_dim(orbital_sh);
    for (int i = 0; i < no; i++) begin
      for (int k = 0; k < nb; k++) begin
        acc = '0;
        for (int l = 0; l < nb; l++) acc = acc + coeff_mem[i*DIM + l] * overlap_at(l, k);
        w[k] = round_q40(acc);
      end
      for (int j = 0; j <= i; j++) begin
        jj = (j == 0) ? i : j - 1;
        acc = '0;
        for (int k = 0; k < nb; k++) acc = acc + coeff_mem[jj*DIM + k] * w[k];
        t = round_q40(acc);
        mag = t[RES_W-1] ? (~t + 64'd1) : t;
        if (jj == i) begin
          dev = (mag >= ONE_Q40) ? mag - ONE_Q40 : ONE_Q40 - mag;
          bad = dev > {17'd0, tol_sh};
        end else begin
          bad = mag > {17'd0, tol_sh};
        end
        if (bad) begin
          v.passed = 1'b0;
          v.row = i[ROW_W-1:0];
          v.col = jj[ROW_W-1:0];
          v.value = t;
          return v;
        end
      end
    end
    return v;
  endfunction

  // element value near the identity pattern, or anything at all
  function automatic logic [VAL_W-1:0] element_value(bit diag, bit wild);
    logic [VAL_W-1:0] base;
    int pick;
    base = diag ? ONE_Q40[VAL_W-1:0] : '0;
    pick = $urandom_range(0, 9);
    if (wild || pick == 9) return {16'($urandom), 32'($urandom)};
    if (pick < 6) return base;
    return base + VAL_W'($signed($urandom_range(0, 30000)) - 15000);
  endfunction

  // offer one transaction, wait for the handshake, then update the shadow
  task automatic send_item(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                           logic [ROW_W-1:0] col, logic [VAL_W-1:0] value,
                           bit typed = 0, verdict_t want = '0);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.row   <= row;
    in_ch.col   <= col;
    in_ch.value <= value;
    // ready is looked at mid-cycle, where nothing moves
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    case (op)
      OP_LOAD_S: begin
        loads_sent++;
        if (col <= row) begin
          overlap_mem[tri_index(row, col)] = value;
          overlap_loaded[tri_index(row, col)] = 1'b1;
        end
      end
      OP_LOAD_C: begin
        loads_sent++;
        coeff_mem[row*DIM + col] = value;
        coeff_loaded[row*DIM + col] = 1'b1;
      end
      OP_CHECK: begin
        checks_sent++;
        verdict_q.push_back(typed ? want : orthonormality_verdict());
      end
      default: ;
    endcase
    // bursts of random length with random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // drop valid and wait until every verdict is in, then let a load finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    burst_left = 0;
  endtask

  // apb write: setup then access, register taken at the access edge
  task automatic reg_write(logic [1:0] idx, logic [63:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_BASIS:   basis_sh = data[CNT_CFG_W-1:0];
      REG_ORBITAL: orbital_sh = data[CNT_CFG_W-1:0];
      REG_TOL:     tol_sh = data[TOL_W-1:0];
      REG_OVERLAP: overlap_sh = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(int nb, int no, logic [TOL_W-1:0] tol, bit ovl);
    drain();
    reg_write(REG_BASIS, 64'(nb));
    reg_write(REG_ORBITAL, 64'(no));
    reg_write(REG_TOL, 64'(tol));
    reg_write(REG_OVERLAP, 64'(ovl));
  endtask

  // load unwritten elements a check at these sizes reads; with wild, all its coefficients
  task automatic fill_missing(bit wild);
    int nb, no;
    nb = clamp_dim(basis_sh);
    no = clamp_dim(orbital_sh);
    for (int r = 0; r < nb; r++)
      for (int c = 0; c <= r; c++)
        if (!overlap_loaded[tri_index(r, c)])
          send_item(OP_LOAD_S, r, c, element_value(r == c, wild));
    for (int i = 0; i < no; i++)
      for (int k = 0; k < nb; k++)
        if (wild || !coeff_loaded[i*DIM + k])
          send_item(OP_LOAD_C, i, k, element_value(i == k, wild));
  endtask

  function automatic step_t cfg_step(logic [1:0] idx, logic [63:0] data);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic step_t item_step(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                                      logic [ROW_W-1:0] col, logic [VAL_W-1:0] value);
    step_t s;
    s = '{default: '0};
    s.op = op;
    s.row = row;
    s.col = col;
    s.value = value;
    return s;
  endfunction

  function automatic step_t check_step(bit typed, verdict_t want);
    step_t s;
    s = item_step(OP_CHECK, 0, 0, 0);
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  // result side: accepted at the edge after a mid-cycle look with valid and ready high
  always @(negedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_ch.passed) passes_seen++;
      else failures_seen++;
      if (verdict_q.size() == 0) begin
        $error("result transaction with no check outstanding");
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.passed !== want.passed) begin
          $error("passed: expected %0d, got %0d", want.passed, out_ch.passed);
          errors++;
        end
        if (out_ch.fail_row !== want.row) begin
          $error("fail_row: expected %0d, got %0d", want.row, out_ch.fail_row);
          errors++;
        end
        if (out_ch.fail_col !== want.col) begin
          $error("fail_col: expected %0d, got %0d", want.col, out_ch.fail_col);
          errors++;
        end
        if (out_ch.fail_value !== want.value) begin
          $error("fail_value: expected %0d, got %0d", want.value, out_ch.fail_value);
          errors++;
        end
      end
    end
  end

  // receiver: stall rate redrawn whenever its timer runs out, plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_timer == 0) begin
        case ($urandom_range(0, 3))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          default: stall_pct = 75;
        endcase
        stall_timer = 50;
      end
      stall_timer = stall_timer - 1;
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    step_t plan [$];
    verdict_t pass_v, zero_fail_v;
    int sent, nb, no, pick;
    logic [TOL_W-1:0] tol;
    logic [OP_W-1:0] op;
    logic [ROW_W-1:0] r, c;

    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    basis_sh = BASIS_RST;
    orbital_sh = ORB_RST;
    tol_sh = TOL_RST;
    overlap_sh = 1'b0;
    pass_v = '0;
    pass_v.passed = 1'b1;
    zero_fail_v = '0;

    // directed plan: reset values, opcode extremes and each corner case
    plan.push_back(check_step(1, pass_v));                               // no overlap yet
    plan.push_back(item_step(OP_LOAD_S, 0, 0, ONE_Q40[VAL_W-1:0]));
    plan.push_back(item_step(OP_LOAD_C, 0, 0, ONE_Q40[VAL_W-1:0]));
    plan.push_back(item_step(OP_LOAD_S, 2, 5, 48'h5555_5555_5555));      // above diagonal
    plan.push_back(item_step(OP_UNUSED, 63, 63, 48'hAAAA_AAAA_AAAA));    // reserved op
    plan.push_back(cfg_step(REG_OVERLAP, 64'd1));
    plan.push_back(check_step(1, pass_v));                               // exact identity
    plan.push_back(item_step(OP_LOAD_C, 0, 0, 48'h7FFF_FFFF_FFFF));
    plan.push_back(check_step(0, '0));
    plan.push_back(item_step(OP_LOAD_C, 0, 0, 48'h8000_0000_0000));
    plan.push_back(check_step(0, '0));
    plan.push_back(cfg_step(REG_TOL, 64'h7FFF_FFFF_FFFF));
    plan.push_back(check_step(0, '0));
    plan.push_back(item_step(OP_LOAD_C, 0, 0, ONE_Q40[VAL_W-1:0]));
    plan.push_back(cfg_step(REG_TOL, 64'd0));
    plan.push_back(check_step(1, pass_v));                               // zero deviation
    plan.push_back(cfg_step(REG_ORBITAL, 64'd0));
    plan.push_back(check_step(1, pass_v));                               // no orbitals
    plan.push_back(cfg_step(REG_BASIS, 64'd0));
    plan.push_back(cfg_step(REG_ORBITAL, 64'd1));
    plan.push_back(check_step(1, zero_fail_v));                          // empty basis, T = 0
    plan.push_back(item_step(OP_LOAD_S, 63, 63, 48'h7FFF_FFFF_FFFF));
    plan.push_back(item_step(OP_LOAD_C, 63, 63, 48'h8000_0000_0000));
    plan.push_back(item_step(OP_LOAD_S, 63, 0, 48'h0123_4567_89AB));
    plan.push_back(item_step(OP_LOAD_C, 0, 63, 48'hFEDC_BA98_7654));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        drain();
        reg_write(plan[n].reg_idx, plan[n].data);
      end else begin
        send_item(plan[n].op, plan[n].row, plan[n].col, plan[n].value,
                  plan[n].typed, plan[n].want);
      end
    end

    // clamped basis count with full-range elements, sums saturate
    configure(127, 1, TOL_RST, 1);
    fill_missing(1);
    send_item(OP_CHECK, 0, 0, 0);
    // clamped orbital count on a single basis function
    configure(1, 100, $urandom_range(0, 1 << 20), 1);
    fill_missing(0);
    send_item(OP_CHECK, 0, 0, 0);
    send_item(OP_LOAD_C, 5, 0, element_value(0, 0));
    send_item(OP_CHECK, 0, 0, 0);

    // back pressure: receiver holds off while quick checks pile up behind it
    configure(2, 2, TOL_RST, 0);
    hold_left = 400;
    for (int n = 0; n < 10; n++) send_item(OP_CHECK, 0, 0, 0);
    drain();

    // random phases: small sizes, identity-like content with noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      nb = (pick == 0) ? 0 : $urandom_range(1, 4);
      no = (pick == 1) ? 0 : $urandom_range(1, 4);
      case ($urandom_range(0, 4))
        0: tol = '0;
        1: tol = '1;
        2: tol = TOL_RST;
        default: tol = $urandom_range(0, 1 << 20);
      endcase
      configure(nb, no, tol, $urandom_range(0, 9) != 0);
      fill_missing(0);
      nb = (clamp_dim(basis_sh) == 0) ? 1 : clamp_dim(basis_sh);
      no = (clamp_dim(orbital_sh) == 0) ? 1 : clamp_dim(orbital_sh);
      for (int n = 0; n < 60; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          r = $urandom_range(0, nb - 1);
          c = $urandom_range(0, r);
          send_item(OP_LOAD_S, r, c, element_value(r == c, 0));
        end else if (pick < 80) begin
          r = $urandom_range(0, no - 1);
          c = $urandom_range(0, nb - 1);
          send_item(OP_LOAD_C, r, c, element_value(r == c, 0));
        end else if (pick < 88) begin
          // stray load anywhere, upper triangle included
          op = $urandom_range(0, 1) ? OP_LOAD_C : OP_LOAD_S;
          send_item(op, $urandom_range(0, 63), $urandom_range(0, 63), element_value(0, 1));
        end else if (pick < 91) begin
          send_item(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                    element_value(0, 1));
        end else begin
          send_item(OP_CHECK, $urandom_range(0, 63), $urandom_range(0, 63),
                    element_value(0, 1));
        end
        sent++;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d loads and %0d checks over many register settings",
             loads_sent, checks_sent);
    $display("verdicts seen: %0d passes, %0d failures, %0d mismatches",
             passes_seen, failures_seen, errors);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
